/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Project form: clk_i and rst_ni of the enclosing module.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

/* hdl/mcc_pkg.sv */
// Shared types, constants and coin table of the fewest-coin change unit.
package mcc_pkg;

  localparam int AMOUNT_W       = 12;
  localparam int DEF_MAX_AMOUNT = 4095;
  localparam int NUM_COINS      = 10;
  localparam int COIN_IDX_W     = 4;
  localparam int COIN_W         = 10;
  localparam int ENTRY_W        = 6;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = 4;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 8;

  localparam logic [ENTRY_W-1:0]    ENTRY_MAX  = 6'd63;
  localparam logic [COIN_IDX_W-1:0] COIN_FIRST = 4'd0;
  localparam logic [COIN_IDX_W-1:0] COIN_LAST  = 4'd9;
  localparam logic [CNT_W-1:0]      CNT_LAST   = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_INIT,
    ST_FILL,
    ST_FWR,
    ST_WRD,
    ST_WCHK
  } state_e;

  // Coin value for each coin index, in trial order.
  function automatic logic [COIN_W-1:0] coin_value(input logic [COIN_IDX_W-1:0] idx);
    logic [COIN_W-1:0] v;
    case (idx)
      4'd0:    v = 10'd1000;
      4'd1:    v = 10'd600;
      4'd2:    v = 10'd480;
      4'd3:    v = 10'd240;
      4'd4:    v = 10'd80;
      4'd5:    v = 10'd60;
      4'd6:    v = 10'd20;
      4'd7:    v = 10'd8;
      4'd8:    v = 10'd5;
      4'd9:    v = 10'd1;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/mcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mcc_alu.sv */
// Shared subtract/compare unit: amount minus the selected coin value.
module mcc_alu #(
  parameter int AW = 12
) (
  input  logic [AW-1:0]                  x_i,
  input  logic [mcc_pkg::COIN_IDX_W-1:0] coin_i,
  output logic [AW-1:0]                  diff_o,
  output logic                           fits_o
);

  localparam int EW = ((AW > mcc_pkg::COIN_W) ? AW : mcc_pkg::COIN_W) + 1;

  logic [EW-1:0] x_ext;
  logic [EW-1:0] c_ext;
  logic [EW-1:0] d_ext;

  // one wide subtract, the borrow tells whether the coin fits
  always_comb begin
    x_ext  = EW'(x_i);
    c_ext  = EW'(mcc_pkg::coin_value(coin_i));
    d_ext  = x_ext - c_ext;
    fits_o = !d_ext[EW-1];
    diff_o = d_ext[AW-1:0];
  end

endmodule

/* hdl/min_coin_change_with_reconstruction_unit.sv */
// Amount 0: the sequencer passes through ST_ZERO and loads one no-coin result into the output register.
// Amount N (after clamping to MAX_AMOUNT): the table fill visits each amount in turn, with up
// to ten reads of the single RAM read port (one per fitting coin) plus one write per amount,
// then the walk back tries coins in ST_WRD and ST_WCHK. One item at a time.
// Reset clears the sequencer and output valid; the table RAM is not cleared.
module min_coin_change_with_reconstruction_unit #(
  parameter int MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // [11:0] amount, [15:12] zero
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,  // [3:0] coin_index, [7:4] zero
  output logic                             m_axis_tuser_o,  // [0] coin_valid
  output logic                             m_axis_tlast_o   // last_coin
);

  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = mcc_pkg::ENTRY_W;
  localparam int IW    = mcc_pkg::COIN_IDX_W;

  mcc_pkg::state_e state_q, state_d;

  logic [AW-1:0]                a_q, a_d;
  logic [AW-1:0]                tgt_q, tgt_d;
  logic [AW-1:0]                rem_q, rem_d;
  logic [IW-1:0]                c_q, c_d;
  logic [EW-1:0]                best_q, best_d;
  logic [EW-1:0]                cur_q, cur_d;
  logic                         pfit_q, pfit_d;
  logic [mcc_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  logic                         out_valid_q, out_valid_d;
  logic [IW-1:0]                out_coin_q, out_coin_d;
  logic                         out_user_q, out_user_d;
  logic                         out_last_q, out_last_d;
  logic                         out_load;
  logic                         out_free;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;

  logic [AW-1:0]                alu_x;
  logic [AW-1:0]                alu_diff;
  logic                         alu_fits;

  logic [31:0]                  amt_ext;
  logic [AW-1:0]                amt_clamped;
  logic                         in_xfer;
  logic [EW:0]                  cand;
  logic [EW-1:0]                best_proc;
  logic                         match;

  // table of fewest coins per amount
  mcc_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared subtractor, used by both fill and walk back
  mcc_alu #(
    .AW (AW)
  ) u_alu (
    .x_i    (alu_x),
    .coin_i (c_q),
    .diff_o (alu_diff),
    .fits_o (alu_fits)
  );

  assign alu_x = ((state_q == mcc_pkg::ST_WRD) || (state_q == mcc_pkg::ST_WCHK))
                 ? rem_q : a_q;

  // input clamp
  assign in_xfer     = s_axis_tvalid_i && s_axis_tready_o;
  assign amt_ext     = 32'(s_axis_tdata_i[mcc_pkg::AMOUNT_W-1:0]);
  assign amt_clamped = (amt_ext > 32'(MAX_AMOUNT)) ? AW'(MAX_AMOUNT) : AW'(amt_ext);

  // candidate from the entry just read; best including it
  assign cand     = {1'b0, ram_rdata} + (EW+1)'(1);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign match    = (pfit_q && (cand == {1'b0, cur_q})) || (c_q == mcc_pkg::COIN_LAST);

  always_comb begin
    best_proc = best_q;
    if (pfit_q && (cand < {1'b0, best_q})) begin
      best_proc = cand[EW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    tgt_d      = tgt_q;
    rem_d      = rem_q;
    c_d        = c_q;
    best_d     = best_q;
    cur_d      = cur_q;
    pfit_d     = pfit_q;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = a_q;
    ram_wdata  = best_proc;
    ram_re     = 1'b0;
    ram_raddr  = alu_diff;
    out_load   = 1'b0;
    out_coin_d = c_q;
    out_user_d = 1'b1;
    out_last_d = 1'b0;

    case (state_q)
      mcc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          tgt_d = amt_clamped;
          rem_d = amt_clamped;
          if (s_axis_tdata_i[mcc_pkg::AMOUNT_W-1:0] == '0) begin
            state_d = mcc_pkg::ST_ZERO;
          end else begin
            state_d = mcc_pkg::ST_INIT;
          end
        end
      end
      mcc_pkg::ST_ZERO: begin
        out_coin_d = mcc_pkg::COIN_FIRST;
        out_user_d = 1'b0;
        out_last_d = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = mcc_pkg::ST_IDLE;
        end
      end
      mcc_pkg::ST_INIT: begin
        // amount zero needs no coins
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        a_d       = AW'(1);
        c_d       = mcc_pkg::COIN_FIRST;
        best_d    = mcc_pkg::ENTRY_MAX;
        pfit_d    = 1'b0;
        state_d   = mcc_pkg::ST_FILL;
      end
      mcc_pkg::ST_FILL: begin
        // issue read for coin c, fold in data of coin c-1
        ram_re = alu_fits;
        pfit_d = alu_fits;
        best_d = best_proc;
        if (c_q == mcc_pkg::COIN_LAST) begin
          state_d = mcc_pkg::ST_FWR;
        end else begin
          c_d = c_q + IW'(1);
        end
      end
      mcc_pkg::ST_FWR: begin
        ram_we = 1'b1;
        c_d    = mcc_pkg::COIN_FIRST;
        pfit_d = 1'b0;
        if (a_q == tgt_q) begin
          cur_d   = best_proc;
          cnt_d   = '0;
          state_d = mcc_pkg::ST_WRD;
        end else begin
          a_d     = a_q + AW'(1);
          best_d  = mcc_pkg::ENTRY_MAX;
          state_d = mcc_pkg::ST_FILL;
        end
      end
      mcc_pkg::ST_WRD: begin
        ram_re  = alu_fits;
        pfit_d  = alu_fits;
        state_d = mcc_pkg::ST_WCHK;
      end
      mcc_pkg::ST_WCHK: begin
        out_last_d = (alu_diff == '0) || (cnt_q == mcc_pkg::CNT_LAST);
        if (match) begin
          if (out_free) begin
            out_load = 1'b1;
            rem_d    = alu_diff;
            c_d      = mcc_pkg::COIN_FIRST;
            if (out_last_d) begin
              rem_d   = '0;
              state_d = mcc_pkg::ST_IDLE;
            end else begin
              cur_d   = cur_q - EW'(1);
              cnt_d   = cnt_q + mcc_pkg::CNT_W'(1);
              state_d = mcc_pkg::ST_WRD;
            end
          end
        end else begin
          c_d     = c_q + IW'(1);
          state_d = mcc_pkg::ST_WRD;
        end
      end
      default: begin
        state_d = mcc_pkg::ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcc_pkg::ST_IDLE;
      c_q         <= mcc_pkg::COIN_FIRST;
      pfit_q      <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      c_q         <= c_d;
      pfit_q      <= pfit_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    tgt_q  <= tgt_d;
    best_q <= best_d;
    cur_q  <= cur_d;
    if (out_load) begin
      out_coin_q <= out_coin_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == mcc_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mcc_pkg::OUT_TDATA_W'(out_coin_q);
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* hdl/mcc_checker.sv */
// Port-level checker for the fewest-coin change unit, bound to the top level.
`include "assert_macros.svh"

module mcc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [mcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [mcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                             m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);

  // one amount at a time: input closes right after a transfer
  `ASSERT_DEF(a_busy_after_in, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input accepted while busy")

  // the no-coin result ends its amount
  `ASSERT_DEF(a_zero_is_last, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o, "no-coin result without last")

  // the no-coin result carries coin index zero
  `ASSERT_DEF(a_zero_idx, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0, "no-coin result with nonzero data")

  // coin index in range, padding zero
  `ASSERT_DEF(a_idx_range, m_axis_tvalid_o |-> m_axis_tdata_o <= mcc_pkg::OUT_TDATA_W'(mcc_pkg::COIN_LAST), "coin index out of range")

  // stalled result holds
  `ASSERT_DEF(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind min_coin_change_with_reconstruction_unit mcc_checker u_mcc_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for the fewest-coin change unit with coin reconstruction.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_AMT     = mcc_pkg::DEF_MAX_AMOUNT;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 400;
  localparam int DUE_DEPTH   = 4096;

  // One expected coin transfer on the result side
  typedef struct packed {
    logic [mcc_pkg::COIN_IDX_W-1:0] coin_index;
    logic                           coin_valid;
    logic                           last_coin;
  } coin_result_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN_FLIP,
    RX_EVERY_8TH,
    RX_SPARSE
  } rx_mode_e;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [mcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;   // [11:0] amount, [15:12] zero
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [mcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;         // [3:0] coin_index, [7:4] zero
  logic                            m_axis_tuser_o;         // [0] coin_valid
  logic                            m_axis_tlast_o;         // last_coin

  // Denominations in trial order, indexed by coin index
  int unsigned denom_value [mcc_pkg::NUM_COINS] = '{1000, 600, 480, 240, 80, 60, 20, 8, 5, 1};

  // Predictor state: fewest coins per amount, plus a ring of the coins still due
  logic [mcc_pkg::ENTRY_W-1:0] fewest_tbl [0:MAX_AMT];
  coin_result_t                due_mem [DUE_DEPTH];
  int                          due_wr = 0;
  int                          due_rd = 0;
  coin_result_t                due_coin;

  int       fail_cnt   = 0;
  int       cycle_cnt  = 0;
  int       burst_left = 0;
  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_mode_left = 0;

  always #10 clk_i = ~clk_i;

  min_coin_change_with_reconstruction_unit #(
    .MAX_AMOUNT(MAX_AMT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Number of coins predicted but not yet seen
  function automatic int coins_pending();
    return due_wr - due_rd;
  endfunction

  // Append one expected coin to the ring
  task automatic store_coin(input coin_result_t r);
    due_mem[due_wr % DUE_DEPTH] = r;
    due_wr++;
  endtask

  // Fill the table up to the amount, then walk back and queue the coins
  task automatic predict_change(input logic [mcc_pkg::AMOUNT_W-1:0] amount);
    int unsigned target;
    int unsigned rest;
    int unsigned best;
    int unsigned cand;
    int          n_coins;
    int          pick;
    bit          found;
    coin_result_t res;
    target = 32'(amount);
    if (target > MAX_AMT) target = MAX_AMT;
    if (target == 0) begin
      res.coin_index = mcc_pkg::COIN_FIRST;
      res.coin_valid = 1'b0;
      res.last_coin  = 1'b1;
      store_coin(res);
      return;
    end
    fewest_tbl[0] = '0;
    for (int unsigned a = 1; a <= target; a++) begin
      best = 32'(mcc_pkg::ENTRY_MAX);
      for (int c = 0; c < mcc_pkg::NUM_COINS; c++) begin
        if (a >= denom_value[c]) begin
          cand = fewest_tbl[a - denom_value[c]] + 1;
          if (cand < best) best = cand;
        end
      end
      fewest_tbl[a] = mcc_pkg::ENTRY_W'(best);
    end
    rest    = target;
    n_coins = 0;
    while (rest > 0 && n_coins < mcc_pkg::MAX_RESULTS) begin
      pick  = int'(mcc_pkg::COIN_LAST);
      found = 1'b0;
      for (int c = 0; c < mcc_pkg::NUM_COINS; c++) begin
        if (!found && rest >= denom_value[c] &&
            int'(fewest_tbl[rest]) == int'(fewest_tbl[rest - denom_value[c]]) + 1) begin
          pick  = c;
          found = 1'b1;
        end
      end
      rest -= denom_value[pick];
      res.coin_index = mcc_pkg::COIN_IDX_W'(pick);
      res.coin_valid = 1'b1;
      res.last_coin  = (rest == 0 || n_coins == mcc_pkg::MAX_RESULTS - 1);
      store_coin(res);
      n_coins++;
    end
  endtask

  // Send one amount; bursts of random length separated by random gaps
  task automatic send_amount(input logic [mcc_pkg::AMOUNT_W-1:0] amount);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 4);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(mcc_pkg::IN_TDATA_W-mcc_pkg::AMOUNT_W){1'b0}}, amount};
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    predict_change(amount);
  endtask

  // Drop valid so that the held item is not taken again
  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic wait_all_coins();
    while (coins_pending() != 0) @(posedge clk_i);
  endtask

  // Zero amount gives a single result flagged as no coin
  task automatic test_zero_amount();
    send_amount('0);
    send_amount(12'd1);
    send_amount('0);
  endtask

  // Every denomination on its own, plus amounts just around the small coins
  task automatic test_single_coins();
    for (int c = 0; c < mcc_pkg::NUM_COINS; c++) begin
      send_amount(mcc_pkg::AMOUNT_W'(denom_value[c]));
    end
    send_amount(12'd4);
    send_amount(12'd7);
    send_amount(12'd9);
  endtask

  // Amounts where taking the largest coin first is not optimal
  task automatic test_non_greedy_amounts();
    send_amount(12'd120);
    send_amount(12'd960);
    send_amount(12'd1200);
    send_amount(12'd999);
  endtask

  // All-ones and alternating bit patterns of the amount field
  task automatic test_bit_extremes();
    send_amount(12'hFFF);
    send_amount(12'hAAA);
    send_amount(12'h555);
  endtask

  // Mostly small amounts, every fifth up to 1023, every twentieth full range
  task automatic test_random_amounts();
    logic [mcc_pkg::AMOUNT_W-1:0] amt;
    for (int i = 0; i < 80; i++) begin
      if (i % 20 == 0) begin
        amt = mcc_pkg::AMOUNT_W'($urandom_range(0, MAX_AMT));
      end else if (i % 5 == 0) begin
        amt = mcc_pkg::AMOUNT_W'($urandom_range(0, 1023));
      end else if ($urandom_range(0, 15) == 0) begin
        amt = '0;
      end else begin
        amt = mcc_pkg::AMOUNT_W'($urandom_range(1, 255));
      end
      send_amount(amt);
      // Hold off midway until every queued coin has come out
      if (i == 40) begin
        stop_sending();
        wait_all_coins();
      end
    end
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (coins_pending() == 0) begin
        $error("unexpected transfer: coin_index %0d coin_valid %0b last_coin %0b",
               m_axis_tdata_o[mcc_pkg::COIN_IDX_W-1:0], m_axis_tuser_o, m_axis_tlast_o);
        fail_cnt++;
      end else begin
        due_coin = due_mem[due_rd % DUE_DEPTH];
        due_rd++;
        if (m_axis_tdata_o[mcc_pkg::COIN_IDX_W-1:0] !== due_coin.coin_index) begin
          $error("coin_index: expected %0d, got %0d",
                 due_coin.coin_index, m_axis_tdata_o[mcc_pkg::COIN_IDX_W-1:0]);
          fail_cnt++;
        end
        if (m_axis_tuser_o !== due_coin.coin_valid) begin
          $error("coin_valid: expected %0b, got %0b", due_coin.coin_valid, m_axis_tuser_o);
          fail_cnt++;
        end
        if (m_axis_tlast_o !== due_coin.last_coin) begin
          $error("last_coin: expected %0b, got %0b", due_coin.last_coin, m_axis_tlast_o);
          fail_cnt++;
        end
      end
    end
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:      m_axis_tready_i <= 1'b1;
      RX_COIN_FLIP: m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_EVERY_8TH: m_axis_tready_i <= (cycle_cnt % 8 == 0);
      default:      m_axis_tready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_amount();
    test_single_coins();
    test_non_greedy_amounts();
    test_bit_extremes();
    test_random_amounts();

    stop_sending();
    wait_all_coins();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && coins_pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
